/* hw/rtl/rau_pkg.sv */
// Package for the rational arithmetic unit: transaction structs, command and
// status codes, sequencer states. No dependencies.
`timescale 1ns / 1ps
package rau_pkg;
  localparam int VALUE_BITS_DEF = 32;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_NUM_OVF = 2'd2,
    ST_DEN_OVF = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] a_num;
    logic [30:0]        a_den;
    logic signed [31:0] b_num;
    logic [30:0]        b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_GCD1,
    S_DIV1,
    S_DIV1B,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_GCD2,
    S_DIV2,
    S_DIV3,
    S_DONE
  } state_t;

  // Request and reply between the sequencer and the shared GCD/divide unit.
  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [63:0] x;
    logic [63:0] y;
  } gd_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } gd_rsp_t;
endpackage

/* hw/rtl/rau_gcd_div.sv */
// Shared iterative unit: binary GCD or restoring 64-bit division, one step
// per cycle. Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_gcd_div (
  input  logic            clk,
  input  logic            rst_n,
  input  rau_pkg::gd_req_t req,
  output rau_pkg::gd_rsp_t rsp
);
  logic        busy_r, busy_nxt;
  logic        div_r, div_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] y_r, y_nxt;
  logic [63:0] q_r, q_nxt;
  logic [63:0] rm_r, rm_nxt;
  logic [5:0]  sh_r, sh_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [63:0] res_r, res_nxt;
  logic [64:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    div_nxt = div_r;
    x_nxt = x_r;
    y_nxt = y_r;
    q_nxt = q_r;
    rm_nxt = rm_r;
    sh_nxt = sh_r;
    cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    res_nxt = res_r;
    trial = {rm_r, q_r[63]} - {1'b0, y_r};
    if (!busy_r) begin
      if (req.start) begin
        busy_nxt = 1'b1;
        div_nxt = req.is_div;
        x_nxt = req.x;
        y_nxt = req.y;
        q_nxt = req.x;
        rm_nxt = '0;
        sh_nxt = '0;
        cnt_nxt = '0;
      end
    end else if (div_r) begin
      if (trial[64]) begin
        rm_nxt = {rm_r[62:0], q_r[63]};
        q_nxt = {q_r[62:0], 1'b0};
      end else begin
        rm_nxt = trial[63:0];
        q_nxt = {q_r[62:0], 1'b1};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt = q_nxt;
      end
    end else begin
      if (x_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt = y_r << sh_r;
      end else if (y_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt = x_r << sh_r;
      end else if (!x_r[0] && !y_r[0]) begin
        x_nxt = x_r >> 1;
        y_nxt = y_r >> 1;
        sh_nxt = sh_r + 6'd1;
      end else if (!x_r[0]) begin
        x_nxt = x_r >> 1;
      end else if (!y_r[0]) begin
        y_nxt = y_r >> 1;
      end else if (x_r > y_r) begin
        x_nxt = y_r;
        y_nxt = x_r - y_r;
      end else begin
        y_nxt = y_r - x_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    div_r <= div_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    q_r <= q_nxt;
    rm_r <= rm_nxt;
    sh_r <= sh_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res = res_r;
endmodule

/* hw/rtl/rational_arith_unit.sv */
// Top level of the rational arithmetic unit: sequencer, shared 33x33 multiplier,
// range check. Depends on rau_pkg and rau_gcd_div.
//
//   channel | ports                    | handshake
//   input   | start, busy, in_item     | accepted when start is high and busy is low
//   result  | out_valid, out_item      | one-cycle strobe, the receiver cannot stall
//
// The shared GCD/divide unit does the GCD and division steps. Add and subtract run a GCD
// and two divisions on the denominators, the multiplier states S_MUL1, S_MUL2 and S_MUL3,
// then a GCD and two divisions for the reduction; multiply and divide go straight to the
// multiplier states. Rejected operands go from S_CHECK straight to S_DONE, and a zero
// numerator goes from S_GCD2 to S_DONE with denominator one. Reset is synchronous,
// active low, and idles the unit.
`timescale 1ns / 1ps
module rational_arith_unit #(
  parameter int VALUE_BITS = rau_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rau_pkg::in_item_t  in_item,
  output logic               out_valid,
  output rau_pkg::out_item_t out_item
);
  rau_pkg::state_t   state_r, state_nxt;
  rau_pkg::in_item_t it_r, it_nxt;
  rau_pkg::gd_req_t  req;
  rau_pkg::gd_rsp_t  rsp;
  rau_pkg::cmd_t     cmd;
  logic [63:0] gd_r, gd_nxt;
  logic [31:0] fa_r, fa_nxt;
  logic [31:0] fb_r, fb_nxt;
  logic [63:0] ta_r, ta_nxt;
  logic [63:0] mag_r, mag_nxt;
  logic [63:0] den_r, den_nxt;
  logic        neg_r, neg_nxt;
  logic        pend_r, pend_nxt;
  rau_pkg::out_item_t res_r, res_nxt;
  logic        ov_r, ov_nxt;

  logic signed [32:0] m_a, m_b;
  logic signed [65:0] m_p;
  logic signed [64:0] s_sum;
  logic        bad;
  logic        addsub;
  logic [63:0] maxpos;
  logic        n_ovf;

  assign cmd = rau_pkg::cmd_t'(it_r.command);
  assign addsub = (cmd == rau_pkg::CMD_ADD) || (cmd == rau_pkg::CMD_SUB);
  assign m_p = m_a * m_b;
  assign maxpos = (64'd1 << (VALUE_BITS - 1)) - 64'd1;
  assign bad = (it_r.a_den == '0) || (it_r.b_den == '0) ||
               (cmd == rau_pkg::CMD_DIV && it_r.b_num == '0);
  assign n_ovf = neg_r ? (rsp.res > maxpos + 64'd1) : (rsp.res > maxpos);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rau_pkg::S_IDLE: if (start) state_nxt = rau_pkg::S_CHECK;
      rau_pkg::S_CHECK: begin
        if (bad) state_nxt = rau_pkg::S_DONE;
        else if (addsub) state_nxt = rau_pkg::S_GCD1;
        else state_nxt = rau_pkg::S_MUL1;
      end
      rau_pkg::S_GCD1: if (rsp.done) state_nxt = rau_pkg::S_DIV1;
      rau_pkg::S_DIV1: if (rsp.done) state_nxt = rau_pkg::S_DIV1B;
      rau_pkg::S_DIV1B: if (rsp.done) state_nxt = rau_pkg::S_MUL1;
      rau_pkg::S_MUL1: state_nxt = rau_pkg::S_MUL2;
      rau_pkg::S_MUL2: state_nxt = rau_pkg::S_MUL3;
      rau_pkg::S_MUL3: state_nxt = rau_pkg::S_GCD2;
      rau_pkg::S_GCD2: begin
        if (mag_r == '0) state_nxt = rau_pkg::S_DONE;
        else if (rsp.done) state_nxt = rau_pkg::S_DIV2;
      end
      rau_pkg::S_DIV2: if (rsp.done) state_nxt = rau_pkg::S_DIV3;
      rau_pkg::S_DIV3: if (rsp.done) state_nxt = rau_pkg::S_DONE;
      rau_pkg::S_DONE: state_nxt = rau_pkg::S_IDLE;
      default: state_nxt = rau_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    it_nxt = it_r;
    gd_nxt = gd_r;
    fa_nxt = fa_r;
    fb_nxt = fb_r;
    ta_nxt = ta_r;
    mag_nxt = mag_r;
    den_nxt = den_r;
    neg_nxt = neg_r;
    pend_nxt = 1'b0;
    res_nxt = res_r;
    ov_nxt = ov_r;
    req = '0;
    m_a = '0;
    m_b = '0;
    s_sum = '0;
    case (state_r)
      rau_pkg::S_IDLE: begin
        if (start) begin
          it_nxt = in_item;
          res_nxt = '0;
        end
      end
      rau_pkg::S_CHECK: begin
        if (bad) res_nxt.status = rau_pkg::ST_DIVZERO;
        else if (addsub) pend_nxt = 1'b1;
      end
      rau_pkg::S_GCD1: begin
        req.start = pend_r;
        req.x = 64'(it_r.a_den);
        req.y = 64'(it_r.b_den);
        if (rsp.done) begin
          gd_nxt = rsp.res;
          pend_nxt = 1'b1;
        end
      end
      rau_pkg::S_DIV1: begin
        req.start = pend_r;
        req.is_div = 1'b1;
        req.x = 64'(it_r.b_den);
        req.y = gd_r;
        if (rsp.done) begin
          fa_nxt = rsp.res[31:0];
          pend_nxt = 1'b1;
        end
      end
      rau_pkg::S_DIV1B: begin
        req.start = pend_r;
        req.is_div = 1'b1;
        req.x = 64'(it_r.a_den);
        req.y = gd_r;
        if (rsp.done) fb_nxt = rsp.res[31:0];
      end
      rau_pkg::S_MUL1: begin
        m_a = 33'(it_r.a_num);
        if (cmd == rau_pkg::CMD_MUL) m_b = 33'(it_r.b_num);
        else if (cmd == rau_pkg::CMD_DIV) m_b = $signed({2'b00, it_r.b_den});
        else m_b = $signed({1'b0, fa_r});
        ta_nxt = 64'(m_p);
      end
      rau_pkg::S_MUL2: begin
        if (addsub) begin
          m_a = 33'(it_r.b_num);
          m_b = $signed({1'b0, fb_r});
          if (cmd == rau_pkg::CMD_ADD)
            s_sum = $signed({ta_r[63], ta_r}) + $signed(m_p[64:0]);
          else
            s_sum = $signed({ta_r[63], ta_r}) - $signed(m_p[64:0]);
        end else begin
          s_sum = $signed({ta_r[63], ta_r});
        end
        if (cmd == rau_pkg::CMD_DIV) neg_nxt = (s_sum < 0) != it_r.b_num[31];
        else neg_nxt = s_sum < 0;
        mag_nxt = s_sum < 0 ? 64'(-s_sum) : 64'(s_sum);
      end
      rau_pkg::S_MUL3: begin
        m_a = $signed({2'b00, it_r.a_den});
        if (cmd == rau_pkg::CMD_MUL) m_b = $signed({2'b00, it_r.b_den});
        else if (cmd == rau_pkg::CMD_DIV)
          m_b = it_r.b_num[31] ? -33'(it_r.b_num) : 33'(it_r.b_num);
        else m_b = $signed({1'b0, fa_r});
        den_nxt = 64'(m_p);
        pend_nxt = 1'b1;
      end
      rau_pkg::S_GCD2: begin
        if (mag_r == '0) begin
          res_nxt.res_den = 31'd1;
        end else begin
          req.start = pend_r;
          req.x = mag_r;
          req.y = den_r;
          if (rsp.done) begin
            gd_nxt = rsp.res;
            pend_nxt = 1'b1;
          end
        end
      end
      rau_pkg::S_DIV2: begin
        req.start = pend_r;
        req.is_div = 1'b1;
        req.x = mag_r;
        req.y = gd_r;
        if (rsp.done) begin
          mag_nxt = rsp.res;
          ov_nxt = n_ovf;
          pend_nxt = 1'b1;
        end
      end
      rau_pkg::S_DIV3: begin
        req.start = pend_r;
        req.is_div = 1'b1;
        req.x = den_r;
        req.y = gd_r;
        if (rsp.done) begin
          if (ov_r) res_nxt.status = rau_pkg::ST_NUM_OVF;
          else if (rsp.res > maxpos) res_nxt.status = rau_pkg::ST_DEN_OVF;
          else begin
            res_nxt.res_num = neg_r ? 32'(-mag_r) : 32'(mag_r);
            res_nxt.res_den = 31'(rsp.res);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rau_pkg::S_IDLE;
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r <= pend_nxt;
    end
    it_r <= it_nxt;
    gd_r <= gd_nxt;
    fa_r <= fa_nxt;
    fb_r <= fb_nxt;
    ta_r <= ta_nxt;
    mag_r <= mag_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
    ov_r <= ov_nxt;
  end

  rau_gcd_div u_gd (
    .clk(clk),
    .rst_n(rst_n),
    .req(req),
    .rsp(rsp)
  );

  assign busy = state_r != rau_pkg::S_IDLE;
  assign out_valid = state_r == rau_pkg::S_DONE;
  assign out_item = res_r;
endmodule
